FILE: rtl/ray_bounded_plane_intersect_macros.svh
// Assertion macros shared by the ray/plane intersection RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef RAY_BOUNDED_PLANE_INTERSECT_MACROS_SVH
`define RAY_BOUNDED_PLANE_INTERSECT_MACROS_SVH

// same-cycle implication
`define RBPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rbpi_pkg.sv
// Package for the ray/plane intersection block: widths, constants, carry type.
// No dependencies.
package rbpi_pkg;

    localparam int unsigned DW = 51;   // dot product and divider width
    localparam int unsigned QW = 31;   // quotient / distance width

    localparam logic [QW-1:0] T_MAX = {QW{1'b1}};
    // 0.0001 in Q.30
    localparam logic signed [DW-1:0] DOT_THRESH = 51'sd107374;

    localparam logic [2:0] REG_NORMAL   = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_EXTENT_X = 3'd4;
    localparam logic [2:0] REG_EXTENT_Y = 3'd5;
    localparam logic [2:0] REG_EXTENT_Z = 3'd6;

    localparam logic [47:0] NORMAL_RESET = 48'h0000_4000_0000;

    typedef logic signed [31:0] t_coord;

    // travels alongside the divider
    typedef struct packed {
        t_coord [2:0]    o;
        t_coord [2:0]    d;
        logic [QW-1:0]   best;
        logic            have;
        logic            flip;
        logic            ok;
    } t_carry;

endpackage

FILE: rtl/rbpi_if.sv
// Channel interfaces for the ray/plane intersection block.
// Depends on rbpi_pkg.
interface rbpi_in_if import rbpi_pkg::*; ();
    logic          valid;
    logic          ready;
    t_coord        origin_x;
    t_coord        origin_y;
    t_coord        origin_z;
    t_coord        dir_x;
    t_coord        dir_y;
    t_coord        dir_z;
    logic [QW-1:0] best_t;
    logic          have_best;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    best_t, have_best, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    best_t, have_best, output ready);
endinterface

interface rbpi_out_if import rbpi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [QW-1:0]      hit_t;
    t_coord             point_x;
    t_coord             point_y;
    t_coord             point_z;
    logic signed [15:0] facing_nx;
    logic signed [15:0] facing_ny;
    logic signed [15:0] facing_nz;

    modport source (output valid, hit, hit_t, point_x, point_y, point_z,
                    facing_nx, facing_ny, facing_nz, input ready);
    modport sink   (input valid, hit, hit_t, point_x, point_y, point_z,
                    facing_nx, facing_ny, facing_nz, output ready);
endinterface

interface rbpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rbpi_div.sv
// Pipelined restoring divider: floor(a * 2^16 / b), one quotient bit per step stage.
// Depends on rbpi_pkg; flags quotients that do not fit in QW bits.
module rbpi_div import rbpi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    input  t_carry        i_carry,
    output logic          o_vld,
    output logic [QW-1:0] o_q,
    output logic          o_sat,
    output t_carry        o_carry
);

    localparam int unsigned NS = QW + 1;

    logic [NS-1:0]         r_vld;
    logic [DW-1:0]         r_rem   [NS];
    logic [DW-1:0]         r_b     [NS];
    logic [QW-1:0]         r_x     [NS];
    logic [QW-1:0]         r_q     [NS];
    logic                  r_sat   [NS];
    t_carry                r_carry [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    // entry: overflow test, top dividend bits as the first partial remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0]   <= {15'd0, i_a} >= {i_b, 15'd0};
            r_rem[0]   <= {15'd0, i_a[DW-1:15]};
            r_x[0]     <= {i_a[14:0], 16'd0};
            r_b[0]     <= i_b;
            r_q[0]     <= '0;
            r_carry[0] <= i_carry;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] trial;
        logic          ge;
        assign trial = {r_rem[k][DW-2:0], r_x[k][QW-1]};
        assign ge    = trial >= r_b[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]   <= ge ? trial - r_b[k] : trial;
                r_q[k+1]     <= {r_q[k][QW-2:0], ge};
                r_x[k+1]     <= {r_x[k][QW-2:0], 1'b0};
                r_b[k+1]     <= r_b[k];
                r_sat[k+1]   <= r_sat[k];
                r_carry[k+1] <= r_carry[k];
            end
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_sat   = r_sat[NS-1];
    assign o_carry = r_carry[NS-1];

endmodule

FILE: rtl/ray_bounded_plane_intersect.sv
// Top level of the bounded ray/plane intersection pipeline.
// Depends on rbpi_pkg, the channel interfaces, rbpi_div and the assertion macros.
//
//  channel   dir  transfer on        payload
//  i_ray     in   valid & ready      origin, direction, best_t, have_best
//  o_hit     out  valid & ready      hit, hit_t, point, facing normal
//  i_cfg     in   valid & ready      index, data (always ready)
//
// One ray enters per cycle unless stalled; stages: four dot-product, 32 divider
// (an entry stage, then one quotient bit each) and three point/extent stages.
// All stages advance together when the output register is empty or taken;
// a stall freezes the whole pipe, nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits, centers and extents; loads NORMAL_RESET.
`include "ray_bounded_plane_intersect_macros.svh"
module ray_bounded_plane_intersect import rbpi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbpi_in_if.sink    i_ray,
    rbpi_out_if.source o_hit,
    rbpi_cfg_if.sink   i_cfg
);

    logic [47:0] r_normal;
    t_coord      r_center [3];
    t_coord      r_extent [3];

    logic signed [15:0] nrm [3];
    logic en;

    assign en          = !o_hit.valid || o_hit.ready;
    assign i_ray.ready = en;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nrm[i] = $signed(r_normal[16*i +: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal <= NORMAL_RESET;
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_extent[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NORMAL:   r_normal    <= i_cfg.data;
                REG_CENTER_X: r_center[0] <= i_cfg.data[31:0];
                REG_CENTER_Y: r_center[1] <= i_cfg.data[31:0];
                REG_CENTER_Z: r_center[2] <= i_cfg.data[31:0];
                REG_EXTENT_X: r_extent[0] <= i_cfg.data[31:0];
                REG_EXTENT_Y: r_extent[1] <= i_cfg.data[31:0];
                REG_EXTENT_Z: r_extent[2] <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: C - O
    logic               r1_vld;
    logic signed [32:0] r1_diff [3];
    t_coord             r1_o    [3];
    t_coord             r1_d    [3];
    logic [QW-1:0]      r1_best;
    logic               r1_have;

    // ---------------- stage 2: products
    logic               r2_vld;
    logic signed [48:0] r2_pn [3];
    logic signed [47:0] r2_pd [3];
    t_coord             r2_o  [3];
    t_coord             r2_d  [3];
    logic [QW-1:0]      r2_best;
    logic               r2_have;

    // ---------------- stage 3: sums
    logic                 r3_vld;
    logic signed [DW-1:0] r3_num;
    logic signed [DW-1:0] r3_dn;
    t_coord               r3_o [3];
    t_coord               r3_d [3];
    logic [QW-1:0]        r3_best;
    logic                 r3_have;

    // ---------------- stage 4: magnitudes and flags
    logic          r4_vld;
    logic [DW-1:0] r4_a;
    logic [DW-1:0] r4_b;
    t_carry        r4_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_ray.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_o[0] <= i_ray.origin_x;
            r1_o[1] <= i_ray.origin_y;
            r1_o[2] <= i_ray.origin_z;
            r1_d[0] <= i_ray.dir_x;
            r1_d[1] <= i_ray.dir_y;
            r1_d[2] <= i_ray.dir_z;
            r1_diff[0] <= {r_center[0][31], r_center[0]} - {i_ray.origin_x[31], i_ray.origin_x};
            r1_diff[1] <= {r_center[1][31], r_center[1]} - {i_ray.origin_y[31], i_ray.origin_y};
            r1_diff[2] <= {r_center[2][31], r_center[2]} - {i_ray.origin_z[31], i_ray.origin_z};
            r1_best <= i_ray.best_t;
            r1_have <= i_ray.have_best;

            for (int i = 0; i < 3; i++) begin
                r2_pn[i] <= r1_diff[i] * nrm[i];
                r2_pd[i] <= r1_d[i] * nrm[i];
                r2_o[i]  <= r1_o[i];
                r2_d[i]  <= r1_d[i];
                r3_o[i]  <= r2_o[i];
                r3_d[i]  <= r2_d[i];
            end
            r2_best <= r1_best;
            r2_have <= r1_have;

            r3_num <= DW'(r2_pn[0]) + DW'(r2_pn[1]) + DW'(r2_pn[2]);
            r3_dn  <= DW'(r2_pd[0]) + DW'(r2_pd[1]) + DW'(r2_pd[2]);
            r3_best <= r2_best;
            r3_have <= r2_have;

            r4_a <= r3_num[DW-1] ? DW'(-r3_num) : DW'(r3_num);
            r4_b <= r3_dn[DW-1]  ? DW'(-r3_dn)  : DW'(r3_dn);
            for (int i = 0; i < 3; i++) begin
                r4_carry.o[i] <= r3_o[i];
                r4_carry.d[i] <= r3_d[i];
            end
            r4_carry.best <= r3_best;
            r4_carry.have <= r3_have;
            r4_carry.flip <= r3_dn > DOT_THRESH;
            // plane in front: both dots nonzero and of the same sign
            r4_carry.ok   <= (r3_num != '0) && (r3_dn != '0) && (r3_num[DW-1] == r3_dn[DW-1]);
        end
    end

    // ---------------- divider
    logic          dv_vld;
    logic [QW-1:0] dv_q;
    logic          dv_sat;
    t_carry        dv_carry;

    rbpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_a     (r4_a),
        .i_b     (r4_b),
        .i_carry (r4_carry),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_sat   (dv_sat),
        .o_carry (dv_carry)
    );

    // ---------------- stage 5: distance checks, t*D
    logic [QW-1:0] qf;
    assign qf = dv_sat ? T_MAX : dv_q;

    logic               r5_vld;
    logic               r5_pre;
    logic               r5_flip;
    logic [QW-1:0]      r5_q;
    logic signed [63:0] r5_prod [3];
    t_coord             r5_o    [3];

    // ---------------- stage 6: point
    logic               r6_vld;
    logic               r6_pre;
    logic               r6_flip;
    logic [QW-1:0]      r6_q;
    logic signed [48:0] r6_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= dv_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_pre  <= dv_carry.ok && (qf != '0) && (!dv_carry.have || (qf < dv_carry.best));
            r5_flip <= dv_carry.flip;
            r5_q    <= qf;
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= $signed({1'b0, qf}) * $signed(dv_carry.d[i]);
                r5_o[i]    <= dv_carry.o[i];
                // floor shift of t*D, then add the origin
                r6_p[i]    <= 49'(r5_o[i]) + 49'(r5_prod[i] >>> 16);
            end
            r6_pre  <= r5_pre;
            r6_flip <= r5_flip;
            r6_q    <= r5_q;
        end
    end

    // ---------------- stage 7: extents, saturation, output register
    logic               inb [3];
    logic signed [49:0] dev [3];
    logic [49:0]        dmag [3];
    t_coord             psat [3];
    logic signed [15:0] fn [3];
    logic               hit_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dev[i]  = 50'(r6_p[i]) - 50'(r_center[i]);
            dmag[i] = dev[i][49] ? 50'(-dev[i]) : 50'(dev[i]);
            inb[i]  = (r_extent[i] <= 0) || (dmag[i] <= 50'(r_extent[i]));
            if (r6_p[i] > 49'sd2147483647) begin
                psat[i] = 32'h7FFF_FFFF;
            end else if (r6_p[i] < -49'sd2147483648) begin
                psat[i] = 32'h8000_0000;
            end else begin
                psat[i] = r6_p[i][31:0];
            end
            // negating full-scale negative clamps to the largest positive
            if (!r6_flip) begin
                fn[i] = nrm[i];
            end else if (nrm[i] == 16'sh8000) begin
                fn[i] = 16'sh7FFF;
            end else begin
                fn[i] = -nrm[i];
            end
        end
        hit_c = r6_pre && inb[0] && inb[1] && inb[2];
    end

    logic r7_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit.hit       <= hit_c;
            o_hit.hit_t     <= hit_c ? r6_q : '0;
            o_hit.point_x   <= hit_c ? psat[0] : '0;
            o_hit.point_y   <= hit_c ? psat[1] : '0;
            o_hit.point_z   <= hit_c ? psat[2] : '0;
            o_hit.facing_nx <= hit_c ? fn[0] : '0;
            o_hit.facing_ny <= hit_c ? fn[1] : '0;
            o_hit.facing_nz <= hit_c ? fn[2] : '0;
        end
    end

    assign o_hit.valid = r7_vld;

    `RBPI_ASSERT_IMP(a_miss_zero, o_hit.valid && !o_hit.hit, o_hit.hit_t == '0 && o_hit.point_x == '0 && o_hit.facing_nx == '0, "miss with nonzero payload")
    `RBPI_ASSERT_IMP(a_hit_t_nonzero, o_hit.valid && o_hit.hit, o_hit.hit_t != '0, "hit with zero distance")
    `RBPI_ASSERT_NXT(a_stall_holds, o_hit.valid && !o_hit.ready, o_hit.valid && $stable(o_hit.hit_t) && $stable(r6_vld), "pipeline moved during stall")
    `RBPI_ASSERT_IMP(a_ready_follows, !o_hit.valid, i_ray.ready, "input not ready with empty output")

endmodule
